// ===== src/bkrt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bkrt_pkg
// Types and constants shared by the BCD keyed record table.
// ----------------------------------------------------------------------------
package bkrt_pkg;

  localparam int KEY_W        = 32;
  localparam int PHONE_W      = 40;
  localparam int ID_DIGITS    = 8;
  localparam int PHONE_DIGITS = 10;
  localparam int PHONE_CHARS  = 11;
  localparam int DASH_POS     = 3;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_DASH = 8'h2d;
  localparam logic [3:0] NIB_MASK   = 4'hf;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_STORED    = 2'd0,
    ST_FULL      = 2'd1,
    ST_CHAR      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SCAN,
    BS_FETCH,
    BS_EMIT,
    BS_RESP
  } back_state_t;

  typedef struct packed {
    kind_t                kind;
    logic [KEY_W-1:0]     key;
    logic [PHONE_W-1:0]   phone;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage : bkrt_pkg
`default_nettype wire

// ===== src/bkrt_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bkrt_in_if / bkrt_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface bkrt_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] id_chars;
  logic [23:0] phone_head;
  logic [55:0] phone_tail;

  modport source (output valid, kind, id_chars, phone_head, phone_tail, input ready);
  modport sink   (input valid, kind, id_chars, phone_head, phone_tail, output ready);
endinterface : bkrt_in_if

interface bkrt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] character;
  logic       last;

  modport source (output valid, status, character, last, input ready);
  modport sink   (input valid, status, character, last, output ready);
endinterface : bkrt_out_if
`default_nettype wire

// ===== src/bkrt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bkrt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bkrt_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : bkrt_ram
`default_nettype wire

// ===== src/bkrt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bkrt_front
// Accepts request items and packs ID and phone text into BCD commands.
// ----------------------------------------------------------------------------
module bkrt_front (
  bkrt_in_if.sink                  in_ch,
  input  wire bkrt_pkg::q_stat_t   q_stat,
  output logic                     push,
  output bkrt_pkg::cmd_t           cmd
);

  function automatic logic [3:0] to_nib(input logic [7:0] ch);
    logic [7:0] d;
    d = ch - bkrt_pkg::ASCII_ZERO;
    return d[3:0] & bkrt_pkg::NIB_MASK;
  endfunction

  logic [bkrt_pkg::KEY_W-1:0]   key;
  logic [bkrt_pkg::PHONE_W-1:0] phone;
  logic [79:0]                  phone_txt;

  assign phone_txt = {in_ch.phone_head, in_ch.phone_tail};

  always_comb begin
    for (int i = 0; i < bkrt_pkg::ID_DIGITS; i++) begin
      key[4*i +: 4] = to_nib(in_ch.id_chars[8*i +: 8]);
    end
    for (int j = 0; j < bkrt_pkg::PHONE_DIGITS; j++) begin
      phone[4*j +: 4] = to_nib(phone_txt[8*j +: 8]);
    end
  end

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;
  assign cmd.kind    = bkrt_pkg::kind_t'(in_ch.kind);
  assign cmd.key     = key;
  assign cmd.phone   = phone;

endmodule : bkrt_front
`default_nettype wire

// ===== src/bkrt_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bkrt_queue
// Two-entry command queue between the front and back sections.
// ----------------------------------------------------------------------------
module bkrt_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire bkrt_pkg::cmd_t    push_cmd,
  input  wire logic              pop,
  output bkrt_pkg::cmd_t         head,
  output bkrt_pkg::q_stat_t      q_stat
);

  bkrt_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head         = q_r[rd_ptr_r];
  assign q_stat.empty = (cnt_r == 2'd0);
  assign q_stat.full  = (cnt_r == 2'd2);

endmodule : bkrt_queue
`default_nettype wire

// ===== src/bkrt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bkrt_back
// Executes inserts and lookups against the key and phone stores and
// drives the registered result channel.
// ----------------------------------------------------------------------------
module bkrt_back #(
  parameter int CAPACITY = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bkrt_pkg::cmd_t    head,
  input  wire bkrt_pkg::q_stat_t q_stat,
  output logic                   pop,
  bkrt_out_if.source             out_ch
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  bkrt_pkg::back_state_t        state_r, state_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [AW-1:0]                idx_r, idx_nxt;
  logic [bkrt_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [bkrt_pkg::PHONE_W-1:0] phone_r, phone_nxt;
  logic [3:0]                   pos_r, pos_nxt;
  bkrt_pkg::status_t            resp_r, resp_nxt;

  logic                         out_valid_r, out_valid_nxt;
  bkrt_pkg::status_t            out_status_r, out_status_nxt;
  logic [7:0]                   out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         emit_ok;
  logic                         ram_we;
  logic [AW-1:0]                key_raddr;
  logic [bkrt_pkg::KEY_W-1:0]   key_rdata;
  logic [bkrt_pkg::PHONE_W-1:0] phone_rdata;

  bkrt_ram #(.WIDTH(bkrt_pkg::KEY_W), .DEPTH(CAPACITY), .ADDR_W(AW)) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (head.key),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  bkrt_ram #(.WIDTH(bkrt_pkg::PHONE_W), .DEPTH(CAPACITY), .ADDR_W(AW)) u_phone_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (head.phone),
    .raddr (idx_r),
    .rdata (phone_rdata)
  );

  assign emit_ok = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    key_nxt        = key_r;
    phone_nxt      = phone_r;
    pos_nxt        = pos_r;
    resp_nxt       = resp_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    pop            = 1'b0;
    ram_we         = 1'b0;
    key_raddr      = idx_r + AW'(1);

    case (state_r)
      bkrt_pkg::BS_IDLE: begin
        key_raddr = '0;
        if (!q_stat.empty) begin
          pop     = 1'b1;
          key_nxt = head.key;
          if (head.kind == bkrt_pkg::KIND_INSERT) begin
            if (count_r == CW'(CAPACITY)) begin
              resp_nxt = bkrt_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              count_nxt = count_r + CW'(1);
              resp_nxt  = bkrt_pkg::ST_STORED;
            end
            state_nxt = bkrt_pkg::BS_RESP;
          end else if (count_r == '0) begin
            resp_nxt  = bkrt_pkg::ST_NOT_FOUND;
            state_nxt = bkrt_pkg::BS_RESP;
          end else begin
            idx_nxt   = '0;
            state_nxt = bkrt_pkg::BS_SCAN;
          end
        end
      end
      bkrt_pkg::BS_SCAN: begin
        if (key_rdata == key_r) begin
          state_nxt = bkrt_pkg::BS_FETCH;
        end else if ((CW'(idx_r) + CW'(1)) == count_r) begin
          resp_nxt  = bkrt_pkg::ST_NOT_FOUND;
          state_nxt = bkrt_pkg::BS_RESP;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      bkrt_pkg::BS_FETCH: begin
        phone_nxt = phone_rdata;
        pos_nxt   = '0;
        state_nxt = bkrt_pkg::BS_EMIT;
      end
      bkrt_pkg::BS_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bkrt_pkg::ST_CHAR;
          out_last_nxt   = (pos_r == 4'(bkrt_pkg::PHONE_CHARS - 1));
          if (pos_r == 4'(bkrt_pkg::DASH_POS)) begin
            out_char_nxt = bkrt_pkg::ASCII_DASH;
          end else begin
            out_char_nxt = {4'd0, phone_r[bkrt_pkg::PHONE_W-1 -: 4]} + bkrt_pkg::ASCII_ZERO;
            phone_nxt    = {phone_r[bkrt_pkg::PHONE_W-5:0], 4'd0};
          end
          pos_nxt = pos_r + 4'd1;
          if (pos_r == 4'(bkrt_pkg::PHONE_CHARS - 1)) begin
            state_nxt = bkrt_pkg::BS_IDLE;
          end
        end
      end
      bkrt_pkg::BS_RESP: begin
        if (emit_ok) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_r;
          out_char_nxt   = 8'd0;
          out_last_nxt   = 1'b1;
          state_nxt      = bkrt_pkg::BS_IDLE;
        end
      end
      default: begin
        state_nxt = bkrt_pkg::BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bkrt_pkg::BS_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    key_r        <= key_nxt;
    phone_r      <= phone_nxt;
    pos_r        <= pos_nxt;
    resp_r       <= resp_nxt;
    out_status_r <= out_status_nxt;
    out_char_r   <= out_char_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

endmodule : bkrt_back
`default_nettype wire

// ===== src/bcd_keyed_record_table.sv =====
`default_nettype none
// Insert: the record is written from the idle state; the back end takes no new
//   command until its status result is registered. Lookup: one stored key per
//   cycle is scanned out of the key RAM; a hit is fetched and its characters
//   are emitted one per cycle while the output is not stalled; a miss gives NOT_FOUND.
// A two-entry command queue lets the input accept while the back end works.
// Reset (synchronous, rst_n low) empties the table and the queue; no sweep.
// ----------------------------------------------------------------------------
// bcd_keyed_record_table
// Record table keyed by a packed BCD ID, returning a formatted phone number.
// ----------------------------------------------------------------------------
module bcd_keyed_record_table #(
  parameter int CAPACITY = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bkrt_in_if.sink    in_ch,
  bkrt_out_if.source out_ch
);

  bkrt_pkg::cmd_t    push_cmd;
  bkrt_pkg::cmd_t    head;
  bkrt_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  bkrt_front u_front (
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push),
    .cmd    (push_cmd)
  );

  bkrt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  bkrt_back #(.CAPACITY(CAPACITY)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule : bcd_keyed_record_table
`default_nettype wire

// ===== src/bkrt_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bkrt_checker
// Port-level checks on the result channel of the record table.
// ----------------------------------------------------------------------------
module bkrt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [7:0] out_character,
  input wire logic       out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_character) && $stable(out_last))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bkrt_pkg::ST_CHAR |-> out_character == 8'd0 && out_last)
    else $error("status result carries a character or is not last");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bkrt_pkg::ST_CHAR |->
      out_character == bkrt_pkg::ASCII_DASH ||
      (out_character >= bkrt_pkg::ASCII_ZERO && out_character <= 8'h3f))
    else $error("phone character out of range");

  a_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_status == bkrt_pkg::ST_CHAR && !out_last
      |=> !out_valid || out_status == bkrt_pkg::ST_CHAR)
    else $error("phone sequence broken by a status result");

endmodule : bkrt_checker

bind bcd_keyed_record_table bkrt_checker u_bkrt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_character (out_ch.character),
  .out_last      (out_ch.last)
);
`default_nettype wire
